// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, clocked on clk and quiet during reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising edge outside reset
`define ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// consequent must hold in the cycle after the trigger
`define ASSERT_NEXT(lbl, trig, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cons)) else $error(msg);

`endif

// File: src/adsc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// adsc_pkg
// shared types and constants of the antenna delay search calibrator
// ----------------------------------------------------------------------------
package adsc_pkg;

	// field widths
	localparam int RANGE_W  = 16;
	localparam int DELAY_W  = 16;
	localparam int TARGET_W = 15;
	localparam int CFG_IDX_W = 2;

	// default group size
	localparam int SAMPLES_DEF = 10;

	// register reset values
	localparam logic [TARGET_W-1:0] TARGET_RST = 15'd1000;
	localparam logic [DELAY_W-1:0]  DELAY_RST  = 16'd16600;
	localparam logic [DELAY_W-1:0]  STEP_RST   = 16'd100;

	// smallest step that keeps the search going
	localparam logic [DELAY_W-1:0]  STEP_MIN   = 16'd3;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TARGET = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DELAY  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STEP   = 2'd2;

	// sign of the last group error
	typedef enum logic [1:0] {
		SIGN_NONE = 2'd0,
		SIGN_POS  = 2'd1,
		SIGN_NEG  = 2'd2
	} sign_t;

	// outcome of one group end
	typedef struct packed {
		logic               finish;
		logic [DELAY_W-1:0] delay;
		logic [DELAY_W-1:0] step;
		sign_t              sign;
	} decision_t;

endpackage
`default_nettype wire

// File: src/antenna_delay_search_calibrator.sv
// result path: the sample closing its group is registered in the input stage, then its result in the result register
// throughput: one range sample per cycle; a group-closing sample waits only while
// the previous result is still held back by the receiver
// a final result closes the search; later samples are taken and dropped
// reset: registers return to 1000 / 16600 / 100, search restarts, no clearing pass
// writing start_delay or start_step restarts the search from the register values
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// antenna_delay_search_calibrator
// step-halving search for the antenna delay over groups of range samples
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module antenna_delay_search_calibrator #(
	parameter int SAMPLES = adsc_pkg::SAMPLES_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	// configuration write
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [adsc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [adsc_pkg::DELAY_W-1:0]       cfg_data,
	// range samples
	input  wire logic                               range_valid,
	output logic                                    range_stall,
	input  wire logic signed [adsc_pkg::RANGE_W-1:0] range_mm,
	// results
	output logic                                    result_valid,
	input  wire logic                               result_stall,
	output logic [adsc_pkg::DELAY_W-1:0]            antenna_delay,
	output logic                                    done_res
);

	localparam int SUM_W = adsc_pkg::RANGE_W + $clog2(SAMPLES);
	localparam int CNT_W = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SAMPLES - 1);

	// configuration registers
	logic signed [SUM_W-1:0]          goal_q;
	logic [adsc_pkg::DELAY_W-1:0]     start_delay_q;
	logic [adsc_pkg::DELAY_W-1:0]     start_step_q;

	// search state
	logic signed [SUM_W-1:0]          sum_q;
	logic [CNT_W-1:0]                 cnt_q;
	logic [adsc_pkg::DELAY_W-1:0]     delay_q;
	logic [adsc_pkg::DELAY_W-1:0]     step_q;
	adsc_pkg::sign_t                  sign_q;
	logic                             finished_q;

	// input stage
	logic                             valid_s1;
	logic signed [adsc_pkg::RANGE_W-1:0] range_s1;

	// result register
	logic                             result_valid_q;
	logic [adsc_pkg::DELAY_W-1:0]     antenna_delay_q;
	logic                             done_q;

	logic                             cfg_write;
	logic                             restart;
	logic                             range_accept;
	logic                             group_end;
	logic                             emits;
	logic                             out_free;
	logic                             fire_s1;
	logic                             res_load;
	logic signed [SUM_W-1:0]          sum_next;
	adsc_pkg::decision_t              dec;

	// configuration handshake, always ready
	assign cfg_ready = 1'b1;
	assign cfg_write = cfg_valid && cfg_ready;
	assign restart   = cfg_write &&
		((cfg_index == adsc_pkg::REG_DELAY) || (cfg_index == adsc_pkg::REG_STEP));

	// stage control
	assign sum_next  = sum_q + SUM_W'(range_s1);
	assign group_end = (cnt_q == CNT_LAST);
	assign emits     = !finished_q && group_end;
	assign out_free  = !result_valid_q || !result_stall;
	assign fire_s1   = valid_s1 && (!emits || out_free);
	assign res_load  = fire_s1 && emits;
	assign range_stall  = valid_s1 && !fire_s1;
	assign range_accept = range_valid && !range_stall;

	adsc_decide #(
		.SUM_W(SUM_W)
	) u_decide (
		.sum       (sum_next),
		.goal      (goal_q),
		.delay     (delay_q),
		.step      (step_q),
		.prev_sign (sign_q),
		.dec       (dec)
	);

	// configuration registers; goal holds the target scaled by the group size
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			goal_q        <= SUM_W'(SAMPLES) * SUM_W'(adsc_pkg::TARGET_RST);
			start_delay_q <= adsc_pkg::DELAY_RST;
			start_step_q  <= adsc_pkg::STEP_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				adsc_pkg::REG_TARGET: goal_q <= SUM_W'(SAMPLES) *
					SUM_W'(cfg_data[adsc_pkg::TARGET_W-1:0]);
				adsc_pkg::REG_DELAY:  start_delay_q <= cfg_data;
				adsc_pkg::REG_STEP:   start_step_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// search state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q      <= '0;
			cnt_q      <= '0;
			delay_q    <= adsc_pkg::DELAY_RST;
			step_q     <= adsc_pkg::STEP_RST;
			sign_q     <= adsc_pkg::SIGN_NONE;
			finished_q <= 1'b0;
		end else if (restart) begin
			sum_q      <= '0;
			cnt_q      <= '0;
			sign_q     <= adsc_pkg::SIGN_NONE;
			finished_q <= 1'b0;
			if (cfg_index == adsc_pkg::REG_DELAY) begin
				delay_q <= cfg_data;
				step_q  <= start_step_q;
			end else begin
				delay_q <= start_delay_q;
				step_q  <= cfg_data;
			end
		end else if (fire_s1 && !finished_q) begin
			if (group_end) begin
				sum_q <= '0;
				cnt_q <= '0;
				if (dec.finish) begin
					finished_q <= 1'b1;
				end else begin
					delay_q <= dec.delay;
					step_q  <= dec.step;
					sign_q  <= dec.sign;
				end
			end else begin
				sum_q <= sum_next;
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	// input stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (range_accept) begin
			valid_s1 <= 1'b1;
		end else if (fire_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	// input stage payload
	always_ff @(posedge clk) begin
		if (range_accept) begin
			range_s1 <= range_mm;
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (res_load) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (res_load) begin
			antenna_delay_q <= dec.delay;
			done_q          <= dec.finish;
		end
	end

	assign result_valid  = result_valid_q;
	assign antenna_delay = antenna_delay_q;
	assign done_res      = done_q;

	// checks
	`ASSERT_ALWAYS(a_cnt_range, cnt_q <= CNT_LAST, "sample count passed the group size")
	`ASSERT_NEXT(a_finish_sets, res_load && dec.finish && !restart, finished_q, "no finish after final")
	`ASSERT_NEXT(a_step_no_grow, !restart, step_q <= $past(step_q), "search step grew without restart")
	`ASSERT_NEXT(a_done_final, res_load && !dec.finish && !restart, !finished_q, "trial set finish")

endmodule
`default_nettype wire

// File: src/adsc_decide.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// adsc_decide
// group end decision: finish check, error sign, step halving, delay update
// ----------------------------------------------------------------------------
module adsc_decide #(
	parameter int SUM_W = 20
) (
	input  wire logic signed [SUM_W-1:0]          sum,
	input  wire logic signed [SUM_W-1:0]          goal,
	input  wire logic [adsc_pkg::DELAY_W-1:0]     delay,
	input  wire logic [adsc_pkg::DELAY_W-1:0]     step,
	input  wire adsc_pkg::sign_t                  prev_sign,
	output adsc_pkg::decision_t                   dec
);

	adsc_pkg::sign_t              sign;
	logic                         halve;
	logic [adsc_pkg::DELAY_W-1:0] step_new;

	// sign of the summed error against the scaled target
	always_comb begin
		if (sum > goal) begin
			sign = adsc_pkg::SIGN_POS;
		end else if (sum < goal) begin
			sign = adsc_pkg::SIGN_NEG;
		end else begin
			sign = adsc_pkg::SIGN_NONE;
		end
	end

	// halve the step on a strict sign reversal
	assign halve = ((sign == adsc_pkg::SIGN_POS) && (prev_sign == adsc_pkg::SIGN_NEG)) ||
		((sign == adsc_pkg::SIGN_NEG) && (prev_sign == adsc_pkg::SIGN_POS));
	assign step_new = halve ? (step >> 1) : step;

	// delay holds on finish, else moves up on a positive error, down otherwise, wrapping
	always_comb begin
		dec.finish = (step < adsc_pkg::STEP_MIN);
		dec.step   = step_new;
		dec.sign   = sign;
		if (dec.finish) begin
			dec.delay = delay;
		end else if (sign == adsc_pkg::SIGN_POS) begin
			dec.delay = delay + step_new;
		end else begin
			dec.delay = delay - step_new;
		end
	end

endmodule
`default_nettype wire

// File: verif/antenna_delay_search_calibrator_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// antenna_delay_search_calibrator_test
// self-checking bench for the step-halving antenna delay search: a short
// table of directed transactions, then random phases of range groups between
// register writes, with random idling on both sides and every delay result
// compared against a typed value or an in-bench model of the search
// ----------------------------------------------------------------------------
module antenna_delay_search_calibrator_test;

	localparam int GROUP       = adsc_pkg::SAMPLES_DEF;
	localparam int ITEM_GOAL   = 1650;
	localparam int MAX_GAP     = 6;
	localparam int LONG_HOLD   = 400;
	localparam int DRAIN       = 6;
	localparam int HOLD_PHASE  = 3;
	localparam int PAUSE_PHASE = 5;
	localparam int MAX_REPORTS = 10;
	localparam int DIR_ROWS    = 11;
	localparam longint LIMIT_NS = 2000000;

	// index with no register behind it
	localparam logic [adsc_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	typedef enum logic {ROW_WRITE, ROW_SAMPLES} row_kind_t;

	typedef struct packed {
		logic [adsc_pkg::DELAY_W-1:0] delay;
		logic                         done;
	} delay_result_t;

	// one directed row: a register write, or a run of identical range samples
	typedef struct packed {
		row_kind_t                      kind;
		logic [adsc_pkg::CFG_IDX_W-1:0] idx;
		logic [adsc_pkg::DELAY_W-1:0]   data;
		logic [7:0]                     reps;
		logic                           typed;
		logic [adsc_pkg::DELAY_W-1:0]   want_delay;
		logic                           want_done;
	} stim_row_t;

	logic                                clk = 1'b0;
	logic                                arst_n = 1'b0;
	logic                                cfg_valid = 1'b0;
	logic                                cfg_ready;
	logic [adsc_pkg::CFG_IDX_W-1:0]      cfg_index = '0;
	logic [adsc_pkg::DELAY_W-1:0]        cfg_data = '0;
	logic                                range_valid = 1'b0;
	logic                                range_stall;
	logic signed [adsc_pkg::RANGE_W-1:0] range_mm = '0;
	logic                                result_valid;
	logic                                result_stall = 1'b0;
	logic [adsc_pkg::DELAY_W-1:0]        antenna_delay;
	logic                                done_res;

	// search model: register copies and running state
	logic [adsc_pkg::TARGET_W-1:0] target_mm;
	logic [adsc_pkg::DELAY_W-1:0]  first_delay;
	logic [adsc_pkg::DELAY_W-1:0]  first_step;
	int                            group_sum;
	int                            group_fill;
	logic [adsc_pkg::DELAY_W-1:0]  trial_delay;
	logic [adsc_pkg::DELAY_W-1:0]  trial_step;
	adsc_pkg::sign_t               last_sign;
	bit                            search_done;

	delay_result_t pending_delays[$];
	stim_row_t     dir_rows [DIR_ROWS];
	int            mismatches = 0;
	int            samples_taken = 0;
	int            tx_gap_max = MAX_GAP;
	int            rx_gap_max = MAX_GAP;
	bit            long_hold_req = 1'b0;

	antenna_delay_search_calibrator #(.SAMPLES(GROUP)) u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.range_valid   (range_valid),
		.range_stall   (range_stall),
		.range_mm      (range_mm),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.antenna_delay (antenna_delay),
		.done_res      (done_res)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// hard stop
	initial begin
		#(LIMIT_NS);
		$display("FAILURE");
		$finish;
	end

	// reload the search from the start registers
	function automatic void restart_search();
		group_sum   = 0;
		group_fill  = 0;
		trial_delay = first_delay;
		trial_step  = first_step;
		last_sign   = adsc_pkg::SIGN_NONE;
		search_done = 1'b0;
	endfunction

	function automatic void apply_register(input logic [adsc_pkg::CFG_IDX_W-1:0] idx,
			input logic [adsc_pkg::DELAY_W-1:0] data);
		case (idx)
			adsc_pkg::REG_TARGET: target_mm = data[adsc_pkg::TARGET_W-1:0];
			adsc_pkg::REG_DELAY: begin
				first_delay = data;
				restart_search();
			end
			adsc_pkg::REG_STEP: begin
				first_step = data;
				restart_search();
			end
			default: ;
		endcase
	endfunction

	// take one sample; returns 1 when it closes a group and a delay comes out
	function automatic bit advance_search(input logic signed [adsc_pkg::RANGE_W-1:0] v,
			output delay_result_t r);
		int              goal;
		adsc_pkg::sign_t s;
		r = '0;
		if (search_done)
			return 1'b0;
		group_sum += int'(v);
		group_fill++;
		if (group_fill < GROUP)
			return 1'b0;
		group_fill = 0;
		// step too small: report the final delay and stop
		if (trial_step < adsc_pkg::STEP_MIN) begin
			search_done = 1'b1;
			group_sum   = 0;
			r.delay     = trial_delay;
			r.done      = 1'b1;
			return 1'b1;
		end
		goal = GROUP * int'(target_mm);
		if (group_sum > goal)
			s = adsc_pkg::SIGN_POS;
		else if (group_sum < goal)
			s = adsc_pkg::SIGN_NEG;
		else
			s = adsc_pkg::SIGN_NONE;
		// sign flip halves the step
		if ((s == adsc_pkg::SIGN_POS && last_sign == adsc_pkg::SIGN_NEG) ||
				(s == adsc_pkg::SIGN_NEG && last_sign == adsc_pkg::SIGN_POS))
			trial_step = trial_step >> 1;
		last_sign = s;
		if (s == adsc_pkg::SIGN_POS)
			trial_delay = trial_delay + trial_step;
		else
			trial_delay = trial_delay - trial_step;
		group_sum = 0;
		r.delay   = trial_delay;
		r.done    = 1'b0;
		return 1'b1;
	endfunction

	// offer one range sample after a random gap and wait for the transaction
	task automatic send_range(input logic signed [adsc_pkg::RANGE_W-1:0] v, output bit got,
			output delay_result_t r);
		int gap;
		gap = $urandom_range(0, tx_gap_max);
		@(negedge clk);
		if (gap > 0) begin
			range_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		range_valid = 1'b1;
		range_mm    = v;
		do @(posedge clk); while (range_stall);
		if (!search_done)
			samples_taken++;
		got = advance_search(v, r);
	endtask

	// stop offering samples until every delay result is back and the pipe is empty
	task automatic drain_results();
		@(negedge clk);
		range_valid = 1'b0;
		while (pending_delays.size() != 0) @(posedge clk);
		repeat (DRAIN) @(negedge clk);
	endtask

	task automatic write_register(input logic [adsc_pkg::CFG_IDX_W-1:0] idx,
			input logic [adsc_pkg::DELAY_W-1:0] data);
		drain_results();
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = data;
		do @(posedge clk); while (!cfg_ready);
		apply_register(idx, data);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// result side: random stall per transaction, one long hold on request
	initial begin : result_side
		int            hold;
		delay_result_t want;
		hold = 0;
		forever begin
			@(posedge clk);
			if (arst_n && result_valid && !result_stall) begin
				if (pending_delays.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("unexpected result: delay %0d done %0b", antenna_delay, done_res);
				end else begin
					want = pending_delays.pop_front();
					if (antenna_delay !== want.delay || done_res !== want.done) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS)
							$display("result mismatch: delay exp %0d got %0d, done exp %0b got %0b",
								want.delay, antenna_delay, want.done, done_res);
					end
				end
				hold = $urandom_range(0, rx_gap_max);
			end
			if (long_hold_req) begin
				hold = LONG_HOLD;
				long_hold_req = 1'b0;
			end
			@(negedge clk);
			result_stall = (hold > 0);
			if (hold > 0)
				hold--;
		end
	end

	initial begin : stimulus
		int                                  phase;
		int                                  groups;
		int                                  style;
		int                                  base;
		int                                  level;
		int                                  tail;
		logic signed [adsc_pkg::RANGE_W-1:0] v;
		bit                                  got;
		delay_result_t                       r;
		stim_row_t                           row;

		// directed table
		dir_rows = '{
			// samples at the extremes, mean well below target: delay falls by the step
			'{ROW_SAMPLES, '0, 16'h7FFF, 8'd5, 1'b0, 16'd0, 1'b0},
			'{ROW_SAMPLES, '0, 16'h8000, 8'd5, 1'b1, 16'd16500, 1'b0},
			'{ROW_WRITE, adsc_pkg::REG_DELAY, 16'h0000, 8'd0, 1'b0, 16'd0, 1'b0},
			'{ROW_WRITE, adsc_pkg::REG_STEP, 16'hFFFF, 8'd0, 1'b0, 16'd0, 1'b0},
			'{ROW_WRITE, adsc_pkg::REG_TARGET, 16'h0000, 8'd0, 1'b0, 16'd0, 1'b0},
			'{ROW_WRITE, REG_UNUSED, 16'hA5A5, 8'd0, 1'b0, 16'd0, 1'b0},
			// zero error falls by the full step and wraps
			'{ROW_SAMPLES, '0, 16'h0000, 8'd10, 1'b1, 16'd1, 1'b0},
			'{ROW_WRITE, adsc_pkg::REG_TARGET, 16'hFFFF, 8'd0, 1'b0, 16'd0, 1'b0},
			'{ROW_WRITE, adsc_pkg::REG_STEP, 16'h0002, 8'd0, 1'b0, 16'd0, 1'b0},
			// step below minimum: final delay straight away
			'{ROW_SAMPLES, '0, 16'h1234, 8'd10, 1'b1, 16'd0, 1'b1},
			// finished: samples dropped
			'{ROW_SAMPLES, '0, 16'hFFFF, 8'd2, 1'b0, 16'd0, 1'b0}
		};

		target_mm   = adsc_pkg::TARGET_RST;
		first_delay = adsc_pkg::DELAY_RST;
		first_step  = adsc_pkg::STEP_RST;
		restart_search();

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed part
		foreach (dir_rows[i]) begin
			row = dir_rows[i];
			if (row.kind == ROW_WRITE) begin
				write_register(row.idx, row.data);
			end else begin
				for (int k = 0; k < row.reps; k++) begin
					send_range(row.data, got, r);
					if (got)
						pending_delays.push_back(row.typed ?
							delay_result_t'({row.want_delay, row.want_done}) : r);
				end
			end
		end

		// random phases: register writes while idle, then groups of samples
		phase = 0;
		while (samples_taken < ITEM_GOAL) begin
			phase++;
			tx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : MAX_GAP;
			rx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : MAX_GAP;
			if (phase == 1 || $urandom_range(0, 2) == 0) begin
				case ($urandom_range(0, 5))
					0: write_register(adsc_pkg::REG_TARGET, 16'h0000);
					1: write_register(adsc_pkg::REG_TARGET, 16'hFFFF);
					2: write_register(adsc_pkg::REG_TARGET, 16'($urandom));
					default: write_register(adsc_pkg::REG_TARGET, 16'($urandom_range(0, 5000)));
				endcase
			end
			if (phase == 1 || search_done || $urandom_range(0, 1) == 0) begin
				case ($urandom_range(0, 4))
					0: write_register(adsc_pkg::REG_DELAY, 16'h0000);
					1: write_register(adsc_pkg::REG_DELAY, 16'hFFFF);
					default: write_register(adsc_pkg::REG_DELAY, 16'($urandom));
				endcase
			end
			if (phase == 1 || $urandom_range(0, 1) == 0) begin
				case ($urandom_range(0, 7))
					0: write_register(adsc_pkg::REG_STEP, 16'($urandom_range(0, 2)));
					1: write_register(adsc_pkg::REG_STEP, adsc_pkg::STEP_MIN);
					2: write_register(adsc_pkg::REG_STEP, 16'hFFFF);
					default: write_register(adsc_pkg::REG_STEP, 16'($urandom_range(4, 300)));
				endcase
			end
			if ($urandom_range(0, 15) == 0)
				write_register(REG_UNUSED, 16'($urandom));
			// back-pressure phase: sender runs flat out while results are held off
			if (phase == HOLD_PHASE) begin
				write_register(adsc_pkg::REG_STEP, 16'd400);
				tx_gap_max    = 0;
				long_hold_req = 1'b1;
			end

			groups = $urandom_range(4, 30);
			for (int g = 0; g < groups; g++) begin
				if (search_done)
					break;
				if (phase == PAUSE_PHASE && g == groups / 2)
					drain_results();
				style = $urandom_range(0, 9);
				base  = int'($urandom_range(0, 80)) - 40;
				for (int k = 0; k < GROUP; k++) begin
					case (style)
						0: v = 16'($urandom);
						1: v = signed'({1'b0, target_mm});
						2: v = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
						default: begin
							// group mean close to the target, sign of the error random
							level = int'(target_mm) + base + int'($urandom_range(0, 30)) - 15;
							if (level > 32767)
								level = 32767;
							v = level[adsc_pkg::RANGE_W-1:0];
						end
					endcase
					send_range(v, got, r);
					if (got)
						pending_delays.push_back(r);
				end
			end

			// broken tail: partial group, or dropped samples after the final delay
			tail = ($urandom_range(0, 3) == 0) ? $urandom_range(1, GROUP - 1) : 0;
			for (int k = 0; k < tail; k++) begin
				send_range(16'($urandom), got, r);
				if (got)
					pending_delays.push_back(r);
			end
		end

		drain_results();
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
